### rtl/rlwq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reentrant lock package
// Shared constants, field widths and result codes of the reentrant lock with
// its first-in first-out wait queue.
// ----------------------------------------------------------------------------
package rlwq_pkg;

	// Default parameter values for the top level.
	localparam int DEF_THREADS   = 64;
	localparam int DEF_COUNT_MAX = 255;

	// Fixed field widths of the request and response items.
	localparam int TID_W      = 6;
	localparam int STATUS_W   = 4;
	localparam int HOLD_W     = 8;
	localparam int WAITERS_W  = 7;
	localparam int MIN_SLOTS  = 64;

	// Requested operation.
	localparam logic FUNC_ACQUIRE = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	// Result codes.
	localparam logic [STATUS_W-1:0] ST_GRANTED     = 4'd0;
	localparam logic [STATUS_W-1:0] ST_REENTERED   = 4'd1;
	localparam logic [STATUS_W-1:0] ST_QUEUED      = 4'd2;
	localparam logic [STATUS_W-1:0] ST_STILL_HELD  = 4'd3;
	localparam logic [STATUS_W-1:0] ST_FREED       = 4'd4;
	localparam logic [STATUS_W-1:0] ST_HANDED_OVER = 4'd5;
	localparam logic [STATUS_W-1:0] ST_NOT_OWNER   = 4'd6;
	localparam logic [STATUS_W-1:0] ST_ALREADY_WTG = 4'd7;
	localparam logic [STATUS_W-1:0] ST_SATURATED   = 4'd8;

endpackage

### rtl/rlwq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module rlwq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read; the read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/reentrant_lock_with_wait_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reentrant lock with wait queue
// One hardware reentrant mutex whose waiters are kept in a first-in
// first-out queue held in a RAM.
// ----------------------------------------------------------------------------
// Usage:
// A request item (func, thread_id) enters on req_valid/req_stall. func 0 is an
// acquire, func 1 a release. Each request gives exactly one response item on
// rsp_valid/rsp_stall carrying the result code, the thread handed the lock
// (if any), the holder and its repeat count, and the number of waiters.
// When a request is accepted the queue RAM is read at the head slot; in the
// next cycle the registered read data is available, and once the output
// register is free the lock state is updated and the response register is
// loaded. The block takes no new request until the current one has loaded
// its response, since it must first wait for the registered RAM read.
// While a response waits in the output register the block still takes the
// next request; that request is then held in the execute cycle until the
// receiver drops rsp_stall. Reset frees the lock, empties the queue and
// clears every waiting mark; the queue RAM itself needs no clearing, since
// only slots that were written are ever popped.
// ----------------------------------------------------------------------------
module reentrant_lock_with_wait_queue
	import rlwq_pkg::*;
#(
	parameter int THREADS   = DEF_THREADS,
	parameter int COUNT_MAX = DEF_COUNT_MAX
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 func,
	input  logic [TID_W-1:0]     thread_id,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [STATUS_W-1:0]  status,
	output logic                 woken_valid,
	output logic [TID_W-1:0]     woken_thread,
	output logic                 holder_valid,
	output logic [TID_W-1:0]     holder_thread,
	output logic [HOLD_W-1:0]    hold_count,
	output logic [WAITERS_W-1:0] waiter_count
);

	// Derived sizes.
	localparam int SLOTS  = (THREADS > MIN_SLOTS) ? THREADS : MIN_SLOTS;
	localparam int PTR_W  = $clog2(SLOTS);
	localparam int FILL_W = $clog2(SLOTS + 1);
	localparam int CNT_RAW_W = $clog2(COUNT_MAX + 1);
	localparam int CNT_W  = (CNT_RAW_W > HOLD_W) ? CNT_RAW_W : HOLD_W;
	localparam int MARKS  = 2 ** TID_W;

	localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(SLOTS - 1);
	localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(SLOTS);
	localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(COUNT_MAX);
	localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

	// Sequencer codes.
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                 state_q;
	logic                 func_q;
	logic [TID_W-1:0]     tid_q;

	logic                 owner_q,    owner_d;
	logic [TID_W-1:0]     owner_id_q, owner_id_d;
	logic [CNT_W-1:0]     cnt_q,      cnt_d;
	logic [PTR_W-1:0]     head_q,     head_d;
	logic [PTR_W-1:0]     tail_q,     tail_d;
	logic [FILL_W-1:0]    fill_q,     fill_d;
	logic [MARKS-1:0]     marks_q,    marks_d;

	logic                 rsp_valid_q;
	logic [STATUS_W-1:0]  status_q,  status_d;
	logic                 woken_q,   woken_d;
	logic [TID_W-1:0]     woken_id_q, woken_id_d;

	logic                 accept;
	logic                 fire;
	logic                 push;
	logic [TID_W-1:0]     head_tid;
	logic                 own_match;

	// Handshake: one request in flight; execution waits for a free response slot.
	assign req_stall = (state_q == ST_EXEC);
	assign accept    = req_valid && !req_stall;
	assign fire      = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);

	// Wait queue storage, read at the head slot when a request is accepted.
	rlwq_ram #(
		.WIDTH (TID_W),
		.DEPTH (SLOTS)
	) u_queue (
		.clk   (clk),
		.we    (push),
		.waddr (tail_q),
		.wdata (tid_q),
		.re    (accept),
		.raddr (head_q),
		.rdata (head_tid)
	);

	assign own_match = owner_q && (owner_id_q == tid_q);

	// Lock update for the request in the execute cycle.
	always_comb begin
		owner_d    = owner_q;
		owner_id_d = owner_id_q;
		cnt_d      = cnt_q;
		head_d     = head_q;
		tail_d     = tail_q;
		fill_d     = fill_q;
		marks_d    = marks_q;
		push       = 1'b0;
		woken_d    = 1'b0;
		woken_id_d = '0;
		status_d   = ST_NOT_OWNER;
		if (func_q == FUNC_ACQUIRE) begin
			if (own_match) begin
				if (cnt_q >= CNT_LIMIT) begin
					status_d = ST_SATURATED;
				end else begin
					cnt_d    = cnt_q + CNT_ONE;
					status_d = ST_REENTERED;
				end
			end else if (!owner_q) begin
				owner_d    = 1'b1;
				owner_id_d = tid_q;
				cnt_d      = CNT_ONE;
				status_d   = ST_GRANTED;
			end else if (marks_q[tid_q] || (fill_q >= FULL_FILL)) begin
				status_d = ST_ALREADY_WTG;
			end else begin
				push           = fire;
				tail_d         = (tail_q == LAST_SLOT) ? '0 : tail_q + PTR_W'(1);
				fill_d         = fill_q + FILL_W'(1);
				marks_d[tid_q] = 1'b1;
				status_d       = ST_QUEUED;
			end
		end else begin
			if (!own_match) begin
				status_d = ST_NOT_OWNER;
			end else if (cnt_q > CNT_ONE) begin
				cnt_d    = cnt_q - CNT_ONE;
				status_d = ST_STILL_HELD;
			end else if (fill_q != '0) begin
				// Final release with waiters: hand the lock to the oldest one.
				head_d            = (head_q == LAST_SLOT) ? '0 : head_q + PTR_W'(1);
				fill_d            = fill_q - FILL_W'(1);
				marks_d[head_tid] = 1'b0;
				owner_id_d        = head_tid;
				cnt_d             = CNT_ONE;
				woken_d           = 1'b1;
				woken_id_d        = head_tid;
				status_d          = ST_HANDED_OVER;
			end else begin
				owner_d    = 1'b0;
				owner_id_d = '0;
				cnt_d      = '0;
				status_d   = ST_FREED;
			end
		end
	end

	// Control and lock state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			owner_q     <= 1'b0;
			owner_id_q  <= '0;
			cnt_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			marks_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= ST_EXEC;
			end else if (fire) begin
				state_q <= ST_IDLE;
			end
			if (fire) begin
				owner_q    <= owner_d;
				owner_id_q <= owner_id_d;
				cnt_q      <= cnt_d;
				head_q     <= head_d;
				tail_q     <= tail_d;
				fill_q     <= fill_d;
				marks_q    <= marks_d;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request capture and response payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			tid_q  <= thread_id;
		end
		if (fire) begin
			status_q   <= status_d;
			woken_q    <= woken_d;
			woken_id_q <= woken_id_d;
		end
	end

	// Holder fields follow the lock registers, which only change on a response.
	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign woken_valid   = woken_q;
	assign woken_thread  = woken_id_q;
	assign holder_valid  = owner_q;
	assign holder_thread = owner_id_q;
	assign hold_count    = cnt_q[HOLD_W-1:0];
	assign waiter_count  = fill_q[WAITERS_W-1:0];

endmodule
